### rtl/core/uvs_pkg.sv
package uvs_pkg;

  // Grid limits and field widths
  localparam int unsigned MAX_GRID = 256;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned RAD_W    = 16;
  localparam int unsigned POS_W    = 17;
  localparam int unsigned TEX_W    = 17;
  localparam int unsigned VTX_W    = 16;

  // Divider: one quotient bit per cell, numerator up to index * 2^32
  localparam int unsigned DIV_W = 40;

  // CORDIC datapath
  localparam int unsigned CORDIC_STAGES = 16;
  localparam int unsigned NSTG  = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
  localparam int unsigned XY_W  = 34;
  localparam int unsigned Z_W   = 32;
  localparam int unsigned SH_W  = 5;
  localparam int unsigned TRIG_W = 32;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [Z_W-1:0] ATAN_PHASE [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  localparam logic [TEX_W-1:0] TEX_ONE = 17'd65536;
  localparam int signed POS_MAX = 65535;

  // Pipeline depth after the input register
  localparam int unsigned LAT = DIV_W + 1 + NSTG + 4;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_RADIUS        = 2'd0,
    CFG_RING_COUNT    = 2'd1,
    CFG_SECTION_COUNT = 2'd2
  } cfg_idx_e;

  // Data that rides along the whole pipeline
  typedef struct packed {
    logic             quad_valid;
    logic [VTX_W-1:0] here;
    logic [VTX_W-1:0] next_section;
    logic [VTX_W-1:0] next_both;
    logic [VTX_W-1:0] next_ring;
  } side_t;

  // Data that rides from the angle stage to the output
  typedef struct packed {
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic [1:0]       quad_t;
    logic [1:0]       quad_p;
  } post_t;

endpackage

### rtl/core/uvs_div_cell.sv
module uvs_div_cell
  import uvs_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [IDX_W-1:0] divisor_i,
  input  logic [IDX_W-1:0] rem_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [DIV_W-1:0] quo_i,
  output logic [IDX_W-1:0] rem_o,
  output logic [DIV_W-1:0] num_o,
  output logic [DIV_W-1:0] quo_o
);

  logic [IDX_W:0]   trial;
  logic             fits;
  logic [IDX_W-1:0] rem_d, rem_q;
  logic [DIV_W-1:0] num_q, quo_q;

  // Bring down the next numerator bit and try the subtract
  assign trial = {rem_i, num_i[DIV_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};
  assign rem_d = fits ? IDX_W'(trial - {1'b0, divisor_i}) : trial[IDX_W-1:0];

  // Advance to the neighbor cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      num_q <= {num_i[DIV_W-2:0], 1'b0};
      quo_q <= {quo_i[DIV_W-2:0], fits};
    end
  end

  assign rem_o = rem_q;
  assign num_o = num_q;
  assign quo_o = quo_q;

endmodule

### rtl/core/uvs_div_chain.sv
module uvs_div_chain
  import uvs_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [IDX_W-1:0] divisor_i,
  input  logic [DIV_W-1:0] num_i,
  output logic [DIV_W-1:0] quo_o
);

  logic [IDX_W-1:0] rem_w [DIV_W+1];
  logic [DIV_W-1:0] num_w [DIV_W+1];
  logic [DIV_W-1:0] quo_w [DIV_W+1];

  assign rem_w[0] = '0;
  assign num_w[0] = num_i;
  assign quo_w[0] = '0;

  // One quotient bit per cell, most significant first
  for (genvar i = 0; i < DIV_W; i++) begin : g_cell
    uvs_div_cell u_cell (
      .clk_i     (clk_i),
      .en_i      (en_i),
      .divisor_i (divisor_i),
      .rem_i     (rem_w[i]),
      .num_i     (num_w[i]),
      .quo_i     (quo_w[i]),
      .rem_o     (rem_w[i+1]),
      .num_o     (num_w[i+1]),
      .quo_o     (quo_w[i+1])
    );
  end

  assign quo_o = quo_w[DIV_W];

endmodule

### rtl/core/uvs_cordic_cell.sv
module uvs_cordic_cell
  import uvs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [SH_W-1:0]        shift_i,
  input  logic [Z_W-1:0]         atan_i,
  input  logic signed [XY_W-1:0] x_i,
  input  logic signed [XY_W-1:0] y_i,
  input  logic signed [Z_W-1:0]  z_i,
  output logic signed [XY_W-1:0] x_o,
  output logic signed [XY_W-1:0] y_o,
  output logic signed [Z_W-1:0]  z_o
);

  logic signed [XY_W-1:0] x_sh, y_sh, x_d, y_d, x_q, y_q;
  logic signed [Z_W-1:0]  z_d, z_q;

  assign x_sh = x_i >>> shift_i;
  assign y_sh = y_i >>> shift_i;

  // Rotate toward zero residual angle
  always_comb begin
    if (!z_i[Z_W-1]) begin
      x_d = x_i - y_sh;
      y_d = y_i + x_sh;
      z_d = z_i - signed'(atan_i);
    end else begin
      x_d = x_i + y_sh;
      y_d = y_i - x_sh;
      z_d = z_i + signed'(atan_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

### rtl/core/uvs_cordic_chain.sv
module uvs_cordic_chain
  import uvs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [Z_W-1:0]  z_i,
  output logic signed [XY_W-1:0] x_o,
  output logic signed [XY_W-1:0] y_o
);

  logic signed [XY_W-1:0] x_w [NSTG+1];
  logic signed [XY_W-1:0] y_w [NSTG+1];
  logic signed [Z_W-1:0]  z_w [NSTG+1];

  assign x_w[0] = CORDIC_GAIN;
  assign y_w[0] = '0;
  assign z_w[0] = z_i;

  // One micro-rotation per cell
  for (genvar i = 0; i < NSTG; i++) begin : g_cell
    uvs_cordic_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (en_i),
      .shift_i (SH_W'(i)),
      .atan_i  (ATAN_PHASE[i]),
      .x_i     (x_w[i]),
      .y_i     (y_w[i]),
      .z_i     (z_w[i]),
      .x_o     (x_w[i+1]),
      .y_o     (y_w[i+1]),
      .z_o     (z_w[i+1])
    );
  end

  assign x_o = x_w[NSTG];
  assign y_o = y_w[NSTG];

endmodule

### rtl/core/uv_sphere_vertex_generator_core.sv
// UV sphere vertex generator.
// Input channel: in_valid_i / in_stall_o carry one grid point (ring_i, section_i)
// per transaction. Output channel: out_valid_o / out_stall_i carry the vertex
// position, texture coordinates, quad flag and four corner indices.
// Configuration: cfg_valid_i / cfg_ready_o write radius, ring count or section
// count by index; write only while no transaction is in flight.
// Throughput: one grid point per cycle while out_stall_i does not hold the
// pipeline. Depth is set by the 40-cell restoring divider chain and the
// CORDIC cell chain.
// The whole pipeline advances together; it holds while a result waits under
// out_stall_i. A one-entry skid register still takes one more input
// transaction during such a hold, then raises in_stall_o until the pipeline
// moves again.
// Reset clears all valid flags and loads radius 1.0, 16 rings and 16
// sections. The pipeline is empty after reset.
module uv_sphere_vertex_generator_core
  import uvs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [IDX_W-1:0]        ring_i,
  input  logic [IDX_W-1:0]        section_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [POS_W-1:0] pos_x_o,
  output logic signed [POS_W-1:0] pos_y_o,
  output logic signed [POS_W-1:0] pos_z_o,
  output logic [TEX_W-1:0]        tex_u_o,
  output logic [TEX_W-1:0]        tex_v_o,
  output logic                    quad_valid_o,
  output logic [VTX_W-1:0]        corner_here_o,
  output logic [VTX_W-1:0]        corner_next_section_o,
  output logic [VTX_W-1:0]        corner_next_both_o,
  output logic [VTX_W-1:0]        corner_next_ring_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [RAD_W-1:0]        cfg_data_i
);

  function automatic logic [CNT_W-1:0] eff_count(logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c < CNT_W'(2)) r = CNT_W'(2);
    else if (c > CNT_W'(MAX_GRID)) r = CNT_W'(MAX_GRID);
    else r = c;
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(logic signed [20:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 21'(POS_MAX)) r = POS_W'(POS_MAX);
    else if (v < -21'(POS_MAX)) r = POS_W'(-POS_MAX);
    else r = v[POS_W-1:0];
    return r;
  endfunction

  function automatic logic [TEX_W-1:0] sat_tex(logic [DIV_W-1:0] q);
    return (q > DIV_W'(TEX_ONE)) ? TEX_ONE : q[TEX_W-1:0];
  endfunction

  // Configuration registers
  logic [RAD_W-1:0] radius_q;
  logic [CNT_W-1:0] ring_count_q, section_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q        <= RAD_W'(256);
      ring_count_q    <= CNT_W'(16);
      section_count_q <= CNT_W'(16);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RADIUS:        radius_q        <= cfg_data_i;
        CFG_RING_COUNT:    ring_count_q    <= cfg_data_i[CNT_W-1:0];
        CFG_SECTION_COUNT: section_count_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] rn, sn;
  logic [IDX_W-1:0] dr, ds;
  logic signed [RAD_W:0] rad_s;

  assign rn    = eff_count(ring_count_q);
  assign sn    = eff_count(section_count_q);
  assign dr    = IDX_W'(rn - CNT_W'(1));
  assign ds    = IDX_W'(sn - CNT_W'(1));
  assign rad_s = signed'({1'b0, radius_q});

  // Pipeline enable and input skid
  logic en, in_acc;
  logic skid_full_q;
  logic [IDX_W-1:0] skid_ring_q, skid_section_q;
  logic v0_q;
  logic [IDX_W-1:0] ring0_q, section0_q;

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = skid_full_q;
  assign in_acc     = in_valid_i && !skid_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
      v0_q        <= 1'b0;
    end else if (en) begin
      skid_full_q <= 1'b0;
      v0_q        <= skid_full_q || in_valid_i;
    end else if (in_acc) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ring0_q    <= skid_full_q ? skid_ring_q : ring_i;
      section0_q <= skid_full_q ? skid_section_q : section_i;
    end
    if (!en && in_acc) begin
      skid_ring_q    <= ring_i;
      skid_section_q <= section_i;
    end
  end

  // Quad flag and corner indices
  side_t side_d;
  logic [VTX_W:0] here_w, below_w, here_n, below_n;

  assign here_w  = 17'(ring0_q) * 17'(sn) + 17'(section0_q);
  assign below_w = here_w + 17'(sn);
  assign here_n  = here_w + 17'd1;
  assign below_n = below_w + 17'd1;

  always_comb begin
    side_d.quad_valid = (ring0_q < dr) && (section0_q < ds);
    if (side_d.quad_valid) begin
      side_d.here         = here_w[VTX_W-1:0];
      side_d.next_section = here_n[VTX_W-1:0];
      side_d.next_both    = below_n[VTX_W-1:0];
      side_d.next_ring    = below_w[VTX_W-1:0];
    end else begin
      side_d.here         = '0;
      side_d.next_section = '0;
      side_d.next_both    = '0;
      side_d.next_ring    = '0;
    end
  end

  // Valid flags and side data travel the full depth
  logic  vld_q  [LAT];
  side_t side_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= v0_q;
      for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int i = 1; i < LAT; i++) side_q[i] <= side_q[i-1];
    end
  end

  // Rounded numerators for the four divisions
  logic [DIV_W-1:0] num_th, num_ph, num_tu, num_tv;
  logic [DIV_W-1:0] quo_th, quo_ph, quo_tu, quo_tv;

  assign num_th = DIV_W'({ring0_q, 31'b0}) + DIV_W'(dr >> 1);
  assign num_ph = DIV_W'({section0_q, 32'b0}) + DIV_W'(ds >> 1);
  assign num_tu = DIV_W'({section0_q, 16'b0}) + DIV_W'(ds >> 1);
  assign num_tv = DIV_W'({ring0_q, 16'b0}) + DIV_W'(dr >> 1);

  uvs_div_chain u_div_th (
    .clk_i(clk_i), .en_i(en), .divisor_i(dr), .num_i(num_th), .quo_o(quo_th)
  );
  uvs_div_chain u_div_ph (
    .clk_i(clk_i), .en_i(en), .divisor_i(ds), .num_i(num_ph), .quo_o(quo_ph)
  );
  uvs_div_chain u_div_tu (
    .clk_i(clk_i), .en_i(en), .divisor_i(ds), .num_i(num_tu), .quo_o(quo_tu)
  );
  uvs_div_chain u_div_tv (
    .clk_i(clk_i), .en_i(en), .divisor_i(dr), .num_i(num_tv), .quo_o(quo_tv)
  );

  // Split off the nearest quarter turn
  logic [Z_W-1:0] ph_t, ph_p, rot_t, rot_p;
  logic [1:0] qt_w, qp_w;
  logic signed [Z_W-1:0] zt_q, zp_q;
  post_t post_d;
  post_t post_q [NSTG+5];

  assign ph_t  = quo_th[Z_W-1:0];
  assign ph_p  = quo_ph[Z_W-1:0];
  assign rot_t = ph_t + 32'h2000_0000;
  assign rot_p = ph_p + 32'h2000_0000;
  assign qt_w  = rot_t[Z_W-1:Z_W-2];
  assign qp_w  = rot_p[Z_W-1:Z_W-2];

  always_comb begin
    post_d.tex_u  = sat_tex(quo_tu);
    post_d.tex_v  = sat_tex(quo_tv);
    post_d.quad_t = qt_w;
    post_d.quad_p = qp_w;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zt_q       <= signed'(ph_t - {qt_w, 30'b0});
      zp_q       <= signed'(ph_p - {qp_w, 30'b0});
      post_q[0]  <= post_d;
      for (int i = 1; i < NSTG + 5; i++) post_q[i] <= post_q[i-1];
    end
  end

  logic signed [XY_W-1:0] xt, yt, xp, yp;

  uvs_cordic_chain u_cordic_t (
    .clk_i(clk_i), .en_i(en), .z_i(zt_q), .x_o(xt), .y_o(yt)
  );
  uvs_cordic_chain u_cordic_p (
    .clk_i(clk_i), .en_i(en), .z_i(zp_q), .x_o(xp), .y_o(yp)
  );

  // Apply the quarter turn
  logic signed [XY_W-1:0] ct_w, st_w, cp_w, sp_w;
  logic signed [TRIG_W-1:0] ct_q, st_q, cp_q, sp_q;

  always_comb begin
    unique case (post_q[NSTG].quad_t)
      2'd0:    begin ct_w = xt;  st_w = yt;  end
      2'd1:    begin ct_w = -yt; st_w = xt;  end
      2'd2:    begin ct_w = -xt; st_w = -yt; end
      default: begin ct_w = yt;  st_w = -xt; end
    endcase
    unique case (post_q[NSTG].quad_p)
      2'd0:    begin cp_w = xp;  sp_w = yp;  end
      2'd1:    begin cp_w = -yp; sp_w = xp;  end
      2'd2:    begin cp_w = -xp; sp_w = -yp; end
      default: begin cp_w = yp;  sp_w = -xp; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ct_q <= ct_w[TRIG_W-1:0];
      st_q <= st_w[TRIG_W-1:0];
      cp_q <= cp_w[TRIG_W-1:0];
      sp_q <= sp_w[TRIG_W-1:0];
    end
  end

  // Direction products
  logic signed [63:0] mx_d, mz_d, mx_q, mz_q;
  logic signed [49:0] my_d, my_q, my2_q;

  assign mx_d = cp_q * st_q;
  assign mz_d = sp_q * st_q;
  assign my_d = -(ct_q * rad_s);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q <= mx_d;
      mz_q <= mz_d;
      my_q <= my_d;
    end
  end

  // Round to Q2.30 and scale by radius
  logic signed [63:0] mx_r, mz_r;
  logic signed [XY_W-1:0] ax, az;
  logic signed [50:0] nx_d, nz_d, nx_q, nz_q;

  assign mx_r = (mx_q + 64'sd536870912) >>> 30;
  assign mz_r = (mz_q + 64'sd536870912) >>> 30;
  assign ax   = mx_r[XY_W-1:0];
  assign az   = mz_r[XY_W-1:0];
  assign nx_d = ax * rad_s;
  assign nz_d = az * rad_s;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q  <= nx_d;
      nz_q  <= nz_d;
      my2_q <= my_q;
    end
  end

  // Round to Q8.8 and saturate
  logic signed [50:0] px_r, pz_r;
  logic signed [49:0] py_r;
  logic signed [POS_W-1:0] px_q, py_q, pz_q;

  assign px_r = (nx_q + 51'sd536870912) >>> 30;
  assign pz_r = (nz_q + 51'sd536870912) >>> 30;
  assign py_r = (my2_q + 50'sd536870912) >>> 30;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= sat_pos(px_r[20:0]);
      pz_q <= sat_pos(pz_r[20:0]);
      py_q <= sat_pos(py_r[20:0]);
    end
  end

  assign out_valid_o           = vld_q[LAT-1];
  assign pos_x_o               = px_q;
  assign pos_y_o               = py_q;
  assign pos_z_o               = pz_q;
  assign tex_u_o               = post_q[NSTG+4].tex_u;
  assign tex_v_o               = post_q[NSTG+4].tex_v;
  assign quad_valid_o          = side_q[LAT-1].quad_valid;
  assign corner_here_o         = side_q[LAT-1].here;
  assign corner_next_section_o = side_q[LAT-1].next_section;
  assign corner_next_both_o    = side_q[LAT-1].next_both;
  assign corner_next_ring_o    = side_q[LAT-1].next_ring;

endmodule

### rtl/core/uvs_checker.sv
module uvs_checker
  import uvs_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic [IDX_W-1:0]        ring_i,
  input logic [IDX_W-1:0]        section_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [POS_W-1:0] pos_x_o,
  input logic signed [POS_W-1:0] pos_y_o,
  input logic signed [POS_W-1:0] pos_z_o,
  input logic [TEX_W-1:0]        tex_u_o,
  input logic [TEX_W-1:0]        tex_v_o,
  input logic                    quad_valid_o,
  input logic [VTX_W-1:0]        corner_here_o,
  input logic [VTX_W-1:0]        corner_next_section_o,
  input logic [VTX_W-1:0]        corner_next_both_o,
  input logic [VTX_W-1:0]        corner_next_ring_o,
  input logic                    cfg_valid_i,
  input logic                    cfg_ready_o,
  input logic [1:0]              cfg_index_i,
  input logic [RAD_W-1:0]        cfg_data_i
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pos_x_o) && $stable(corner_here_o))
    else $error("stalled result changed");

  // Skid fills only while the output is held
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output hold");

  // Drop input stall once the pipeline moves
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !(out_valid_o && out_stall_i) |=> !in_stall_o)
    else $error("skid did not drain");

  // Zero corners without a quad
  a_no_quad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !quad_valid_o |-> corner_here_o == '0 && corner_next_section_o == '0
      && corner_next_both_o == '0 && corner_next_ring_o == '0)
    else $error("corner index without quad");

  // Texture coordinates stay within one
  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tex_u_o <= TEX_ONE && tex_v_o <= TEX_ONE)
    else $error("texture coordinate above one");

endmodule

bind uv_sphere_vertex_generator_core uvs_checker u_uvs_checker (.*);

### tb/uvs_vertex_checker.sv
module uvs_vertex_checker
  import uvs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [IDX_W-1:0]        ring_i,
  input  logic [IDX_W-1:0]        section_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] pos_z_i,
  input  logic [TEX_W-1:0]        tex_u_i,
  input  logic [TEX_W-1:0]        tex_v_i,
  input  logic                    quad_valid_i,
  input  logic [VTX_W-1:0]        corner_here_i,
  input  logic [VTX_W-1:0]        corner_next_section_i,
  input  logic [VTX_W-1:0]        corner_next_both_i,
  input  logic [VTX_W-1:0]        corner_next_ring_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [RAD_W-1:0]        cfg_data_i,
  output int                      fail_cnt_o,
  output int                      pending_o
);

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic                    quad_valid;
    logic [VTX_W-1:0]        here;
    logic [VTX_W-1:0]        next_section;
    logic [VTX_W-1:0]        next_both;
    logic [VTX_W-1:0]        next_ring;
  } vertex_t;

  logic [RAD_W-1:0] radius_q;
  logic [CNT_W-1:0] rings_q;
  logic [CNT_W-1:0] sections_q;
  vertex_t          vertex_q[$];
  int               fails;

  assign fail_cnt_o = fails;
  assign pending_o  = vertex_q.size();

  function automatic longint clamp_count(logic [CNT_W-1:0] c);
    if (c < 2) return 2;
    if (c > MAX_GRID) return MAX_GRID;
    return c;
  endfunction

  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip_pos(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < -POS_MAX) return -POS_MAX;
    return v;
  endfunction

  function automatic logic [TEX_W-1:0] tex_frac(longint idx, longint d);
    longint t;
    t = (idx * 65536 + d / 2) / d;
    return (t > 65536) ? TEX_ONE : TEX_W'(t);
  endfunction

  // Rotate from the nearest quarter turn, then fold the quadrant back in
  function automatic void sin_cos(input logic [31:0] phase, output longint c,
                                  output longint s);
    logic [1:0] q;
    longint     z, x, y, nx, ny;
    q = 2'((phase + 32'h2000_0000) >> 30);
    z = longint'({32'b0, phase}) - longint'(q) * 64'sh4000_0000;
    x = CORDIC_GAIN;
    y = 0;
    if (z >= 64'sh8000_0000) z -= 64'sh1_0000_0000;
    for (int i = 0; i < NSTG; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= longint'(ATAN_PHASE[i]);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += longint'(ATAN_PHASE[i]);
      end
      x = nx;
      y = ny;
    end
    case (q)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic vertex_t predict_vertex(longint ring, longint section);
    vertex_t     v;
    longint      rn, sn, dr, ds, ct, st, cp, sp, r, here, below;
    logic [31:0] th, ph;
    rn = clamp_count(rings_q);
    sn = clamp_count(sections_q);
    dr = rn - 1;
    ds = sn - 1;
    r  = radius_q;
    th = 32'(((ring << 31) + dr / 2) / dr);
    ph = 32'(((section << 32) + ds / 2) / ds);
    sin_cos(th, ct, st);
    sin_cos(ph, cp, sp);
    v.pos_x = POS_W'(clip_pos(round_shift(round_shift(cp * st, 30) * r, 30)));
    v.pos_z = POS_W'(clip_pos(round_shift(round_shift(sp * st, 30) * r, 30)));
    v.pos_y = POS_W'(clip_pos(round_shift(-ct * r, 30)));
    v.tex_u = tex_frac(section, ds);
    v.tex_v = tex_frac(ring, dr);
    v.quad_valid = (ring < dr) && (section < ds);
    here  = ring * sn + section;
    below = (ring + 1) * sn + section;
    // No quad here: all corners read zero
    v.here         = v.quad_valid ? VTX_W'(here) : '0;
    v.next_section = v.quad_valid ? VTX_W'(here + 1) : '0;
    v.next_both    = v.quad_valid ? VTX_W'(below + 1) : '0;
    v.next_ring    = v.quad_valid ? VTX_W'(below) : '0;
    return v;
  endfunction

  // Track registers, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t got, want;
    if (!rst_ni) begin
      radius_q   <= 16'd256;
      rings_q    <= 9'd16;
      sections_q <= 9'd16;
      vertex_q.delete();
      fails      <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_RADIUS:        radius_q   <= cfg_data_i;
          CFG_RING_COUNT:    rings_q    <= cfg_data_i[CNT_W-1:0];
          CFG_SECTION_COUNT: sections_q <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        vertex_q.insert(vertex_q.size(), predict_vertex(ring_i, section_i));
      if (out_valid_i && !out_stall_i) begin
        got = '{pos_x_i, pos_y_i, pos_z_i, tex_u_i, tex_v_i, quad_valid_i,
                corner_here_i, corner_next_section_i, corner_next_both_i,
                corner_next_ring_i};
        if (vertex_q.size() == 0) begin
          if (fails < 10) $display("unexpected vertex result: %p", got);
          fails <= fails + 1;
        end else begin
          want = vertex_q.pop_front();
          if (got !== want) begin
            if (fails < 10) $display("vertex mismatch: expected %p actual %p", want, got);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

### tb/tb_uv_sphere_vertex_generator_core.sv
module tb_uv_sphere_vertex_generator_core;
  import uvs_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [IDX_W-1:0]        ring_i = '0;
  logic [IDX_W-1:0]        section_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [POS_W-1:0] pos_x_o, pos_y_o, pos_z_o;
  logic [TEX_W-1:0]        tex_u_o, tex_v_o;
  logic                    quad_valid_o;
  logic [VTX_W-1:0]        corner_here_o, corner_next_section_o;
  logic [VTX_W-1:0]        corner_next_both_o, corner_next_ring_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [1:0]              cfg_index_i = '0;
  logic [RAD_W-1:0]        cfg_data_i = '0;
  int                      fail_cnt, pending;
  logic                    quiet = 1'b0;
  int                      rings_eff = 16, sections_eff = 16;

  always #2 clk_i = ~clk_i;

  uv_sphere_vertex_generator_core uut (.*);

  uvs_vertex_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .ring_i, .section_i,
    .out_valid_i(out_valid_o), .out_stall_i, .pos_x_i(pos_x_o), .pos_y_i(pos_y_o),
    .pos_z_i(pos_z_o), .tex_u_i(tex_u_o), .tex_v_i(tex_v_o),
    .quad_valid_i(quad_valid_o), .corner_here_i(corner_here_o),
    .corner_next_section_i(corner_next_section_o),
    .corner_next_both_i(corner_next_both_o), .corner_next_ring_i(corner_next_ring_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // Stall the result side at random outside the quiet stretch
  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 11);
  end

  function automatic int clamp_count(logic [CNT_W-1:0] c);
    if (c < 2) return 2;
    if (c > MAX_GRID) return MAX_GRID;
    return c;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [RAD_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_RING_COUNT) rings_eff = clamp_count(data[CNT_W-1:0]);
    if (idx == CFG_SECTION_COUNT) sections_eff = clamp_count(data[CNT_W-1:0]);
  endtask

  task automatic send_point(logic [IDX_W-1:0] ring, logic [IDX_W-1:0] section);
    if (!quiet && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    ring_i     <= ring;
    section_i  <= section;
    in_valid_i <= 1'b1;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Hold the sender until every vertex is back, then let the pipe settle
  task automatic drain_all();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LAT + 8) @(posedge clk_i);
  endtask

  task automatic random_points(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 85)
        send_point(IDX_W'($urandom_range(rings_eff - 1)),
                   IDX_W'($urandom_range(sections_eff - 1)));
      else
        send_point(IDX_W'($urandom_range(255)), IDX_W'($urandom_range(255)));
    end
  endtask

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: grid corners, poles, seam and points off the grid
    send_point(0, 0);
    send_point(15, 15);
    send_point(14, 14);
    send_point(14, 15);
    send_point(15, 14);
    send_point(7, 8);
    send_point(1, 1);
    send_point(8, 4);
    send_point(255, 255);
    send_point(0, 255);
    send_point(255, 0);
    send_point(16, 16);
    send_point(8'haa, 8'h55);
    send_point(8'h55, 8'haa);
    drain_all();

    write_reg(CFG_RADIUS, 16'hffff);
    write_reg(CFG_RING_COUNT, 16'd2);
    write_reg(CFG_SECTION_COUNT, 16'd2);
    send_point(0, 0);
    send_point(1, 1);
    send_point(0, 1);
    send_point(2, 0);
    drain_all();

    // Largest grid, zero radius, spare index must be ignored
    write_reg(CFG_RADIUS, 16'd0);
    write_reg(CFG_RING_COUNT, 16'd256);
    write_reg(CFG_SECTION_COUNT, 16'd256);
    write_reg(CFG_SPARE, 16'h1234);
    send_point(254, 254);
    send_point(255, 255);
    send_point(128, 64);
    drain_all();

    // Random phases across settings, extremes and clamped counts among them
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_RADIUS, 16'hffff);
          write_reg(CFG_RING_COUNT, 16'd256);
          write_reg(CFG_SECTION_COUNT, 16'd256);
        end
        1: begin
          write_reg(CFG_RADIUS, 16'h8000);
          write_reg(CFG_RING_COUNT, 16'd0);
          write_reg(CFG_SECTION_COUNT, 16'd1);
        end
        2: begin
          write_reg(CFG_RADIUS, 16'd256);
          write_reg(CFG_RING_COUNT, 16'hfe01);
          write_reg(CFG_SECTION_COUNT, 16'd300);
        end
        3: quiet = 1'b1;
        4: begin
          quiet = 1'b0;
          write_reg(CFG_RADIUS, 16'd1);
          write_reg(CFG_RING_COUNT, 16'd3);
          write_reg(CFG_SECTION_COUNT, 16'd255);
        end
        default: begin
          write_reg(CFG_RADIUS, RAD_W'($urandom_range(16'hffff)));
          write_reg(CFG_RING_COUNT, RAD_W'($urandom_range(16'hffff)));
          write_reg(CFG_SECTION_COUNT, RAD_W'($urandom_range(2, 256)));
          write_reg(CFG_SPARE, RAD_W'($urandom_range(16'hffff)));
        end
      endcase
      random_points(190);
      drain_all();
    end

    if (fail_cnt == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
